@@ design/lppd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer package
// Byte class codes and field widths shared by the deframer and its checker.
// ----------------------------------------------------------------------------
package lppd_pkg;

    localparam int BYTE_W  = 8;
    localparam int CLASS_W = 3;
    localparam int REM_W   = 17;

    localparam logic [CLASS_W-1:0] CLASS_DISCARD  = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_HEADER   = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_LEN_HI   = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_LEN_LO   = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_PAYLOAD  = 3'd4;
    localparam logic [CLASS_W-1:0] CLASS_CHECKSUM = 3'd5;

    localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hAA;

endpackage

@@ design/length_prefixed_packet_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Classifies each received byte as discarded, header, length, payload or
// checksum, and checks the checksum against the wrapping sum of the payload.
// ----------------------------------------------------------------------------
// Latency: a result item is valid the cycle after its input item is accepted.
// Throughput: one item per cycle; the single result register is refilled in
// the same cycle it is taken, so only a stalled output holds off the input.
// Reset: rst_n (asynchronous, active low) returns the parser to hunting,
// clears the length and sum, and restores the header byte to 0xAA.
module length_prefixed_packet_deframer
    import lppd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [BYTE_W-1:0]  cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [BYTE_W-1:0]  rx_byte,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [BYTE_W-1:0]  byte_out,
    output logic [CLASS_W-1:0] byte_class,
    output logic               packet_end,
    output logic               checksum_ok
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_BODY
    } phase_t;

    phase_t              phase_reg,       phase_next;
    logic [REM_W-1:0]    remaining_reg,   remaining_next;
    logic [BYTE_W-1:0]   running_sum_reg, running_sum_next;
    logic [BYTE_W-1:0]   header_byte_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   byte_out_reg;
    logic [CLASS_W-1:0]  byte_class_reg,  byte_class_next;
    logic                packet_end_reg,  packet_end_next;
    logic                checksum_ok_reg, checksum_ok_next;

    logic                in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        phase_next       = phase_reg;
        remaining_next   = remaining_reg;
        running_sum_next = running_sum_reg;
        byte_class_next  = CLASS_DISCARD;
        packet_end_next  = 1'b0;
        checksum_ok_next = 1'b0;
        case (phase_reg)
            PH_HUNT:
            begin
                if (rx_byte == header_byte_reg)
                begin
                    byte_class_next  = CLASS_HEADER;
                    phase_next       = PH_LEN_HI;
                    running_sum_next = '0;
                    remaining_next   = '0;
                end
            end
            PH_LEN_HI:
            begin
                byte_class_next = CLASS_LEN_HI;
                remaining_next  = {1'b0, rx_byte, 8'h00};
                phase_next      = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                // Count the checksum byte along with the payload bytes.
                byte_class_next  = CLASS_LEN_LO;
                remaining_next   = {1'b0, remaining_reg[15:8], rx_byte} + REM_W'(1);
                running_sum_next = '0;
                phase_next       = PH_BODY;
            end
            PH_BODY:
            begin
                if (remaining_reg > REM_W'(1))
                begin
                    byte_class_next  = CLASS_PAYLOAD;
                    running_sum_next = running_sum_reg + rx_byte;
                    remaining_next   = remaining_reg - REM_W'(1);
                end
                else
                begin
                    byte_class_next  = CLASS_CHECKSUM;
                    packet_end_next  = 1'b1;
                    checksum_ok_next = (running_sum_reg == rx_byte);
                    phase_next       = PH_HUNT;
                    remaining_next   = '0;
                    running_sum_next = '0;
                end
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            remaining_reg   <= '0;
            running_sum_reg <= '0;
            header_byte_reg <= HEADER_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                header_byte_reg <= cfg_data;
            end
            if (in_fire)
            begin
                phase_reg       <= phase_next;
                remaining_reg   <= remaining_next;
                running_sum_reg <= running_sum_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            byte_out_reg    <= rx_byte;
            byte_class_reg  <= byte_class_next;
            packet_end_reg  <= packet_end_next;
            checksum_ok_reg <= checksum_ok_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign byte_out    = byte_out_reg;
    assign byte_class  = byte_class_reg;
    assign packet_end  = packet_end_reg;
    assign checksum_ok = checksum_ok_reg;

endmodule

@@ design/lppd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer checker
// Port-level assertions on the result stream of the deframer.
// ----------------------------------------------------------------------------
module lppd_checker
    import lppd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic [BYTE_W-1:0]  byte_out,
    input  logic [CLASS_W-1:0] byte_class,
    input  logic               packet_end,
    input  logic               checksum_ok
);

    logic [CLASS_W-1:0] last_class_reg;

    // Class of the last item delivered on the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_class_reg <= CLASS_DISCARD;
        end
        else if (out_valid && out_ready)
        begin
            last_class_reg <= byte_class;
        end
    end

    a_end_is_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packet_end == (byte_class == CLASS_CHECKSUM)))
        else $error("packet_end does not match the checksum class");

    a_ok_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && checksum_ok) |-> packet_end)
        else $error("checksum_ok raised outside packet end");

    a_header_then_len_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_class_reg == CLASS_HEADER) |-> (byte_class == CLASS_LEN_HI))
        else $error("header item not followed by length high item");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(byte_out) && $stable(byte_class)))
        else $error("stalled result item changed");

endmodule

bind length_prefixed_packet_deframer lppd_checker u_lppd_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .byte_out    (byte_out),
    .byte_class  (byte_class),
    .packet_end  (packet_end),
    .checksum_ok (checksum_ok)
);
